// ===== rtl/snake_order_matrix_sort_top_macros.svh =====
// Assertion macros used by the snake-order matrix sort checker
`ifndef SNAKE_ORDER_MATRIX_SORT_TOP_MACROS_SVH
`define SNAKE_ORDER_MATRIX_SORT_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define SOMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("snake sort check failed");

// check a property on every clock edge, reset included
`define SOMS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("snake sort check failed during reset");

`endif

// ===== rtl/soms_pkg.sv =====
// Shared constants and types of the snake-order matrix sort
`default_nettype none
package soms_pkg;

    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;

    localparam int VALUE_W    = 32;
    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int DIMC_W     = 5;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;

    localparam logic [CNT_W-1:0] CNT_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT_RD,
        ST_SORT_LD,
        ST_SORT_CMP,
        ST_SORT_INS,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/snake_order_matrix_sort_top.sv =====
// Snake-order matrix sort: load, stable sort in memory, snake placement, row-major emission
//
// Values enter one word per cycle in row-major order until rows*cols have arrived (rows and
// cols clamped to 1..MAX_ROWS and 1..MAX_COLS). The block then runs a stable insertion sort
// from the arrival store into a second memory, one read-compare-write step per cycle through
// the sorted memory port. Emission reads, loads and then holds each result word until it is
// taken (EMIT_RD, EMIT_LD, EMIT_WAIT); each word carries its row, column and a last flag.
// No input is taken during sort and emission. Loading resumes in the cycle after the last
// result word is taken. The memories need no clearing after reset. Configuration is written
// between frames.
`default_nettype none
module snake_order_matrix_sort_top #(
    parameter int MAX_ROWS = soms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = soms_pkg::MAX_COLS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [soms_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [soms_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // fields from bit 0: value[31:0]
    input  wire logic [soms_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // fields from bit 0: out_value[31:0], out_row[34:32], out_col[37:35], zero pad[39:38]
    output logic [soms_pkg::M_TDATA_W-1:0]        o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int CAPACITY = MAX_ROWS * MAX_COLS;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int TOT_W    = $clog2(CAPACITY + 1);
    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    localparam logic [soms_pkg::DIMC_W-1:0] MAXR = soms_pkg::DIMC_W'(MAX_ROWS);
    localparam logic [soms_pkg::DIMC_W-1:0] MAXC = soms_pkg::DIMC_W'(MAX_COLS);
    localparam logic [soms_pkg::DIMC_W-1:0] DIM_ONE = soms_pkg::DIMC_W'(1);

    soms_pkg::t_state r_state, n_state;

    logic [soms_pkg::DIM_W-1:0]  r_rows;
    logic [soms_pkg::DIM_W-1:0]  r_cols;
    logic                        r_mode;
    logic [soms_pkg::CNT_W-1:0]  r_count, n_count;
    logic [TOT_W-1:0]            r_i, n_i;
    logic [TOT_W-1:0]            r_j, n_j;
    logic [RW-1:0]               r_r, n_r;
    logic [CW-1:0]               r_c, n_c;
    logic signed [soms_pkg::VALUE_W-1:0] r_val, n_val;
    logic signed [soms_pkg::VALUE_W-1:0] r_out_value, n_out_value;
    logic [soms_pkg::IDX_W-1:0]  r_out_row, n_out_row;
    logic [soms_pkg::IDX_W-1:0]  r_out_col, n_out_col;
    logic                        r_out_last, n_out_last;

    logic signed [soms_pkg::VALUE_W-1:0] r_store [CAPACITY];
    logic signed [soms_pkg::VALUE_W-1:0] r_sorted [CAPACITY];
    logic signed [soms_pkg::VALUE_W-1:0] r_st_rdata;
    logic signed [soms_pkg::VALUE_W-1:0] r_so_rdata;

    logic                                st_we;
    logic [AW-1:0]                       st_wa;
    logic [AW-1:0]                       st_ra;
    logic                                so_we;
    logic [AW-1:0]                       so_wa;
    logic signed [soms_pkg::VALUE_W-1:0] so_wd;
    logic [AW-1:0]                       so_ra;

    logic [soms_pkg::DIMC_W-1:0] nr, nc;
    logic [TOT_W-1:0]            nr_t, nc_t, total;
    logic [TOT_W-1:0]            snake_k;
    logic [soms_pkg::CNT_W-1:0]  cnt_inc;
    logic [TOT_W-1:0]            i_inc;
    logic                        ins_done;

    // clamp the matrix size
    always_comb begin
        if (r_rows == '0) begin
            nr = DIM_ONE;
        end else if ({1'b0, r_rows} > MAXR) begin
            nr = MAXR;
        end else begin
            nr = {1'b0, r_rows};
        end
        if (r_cols == '0) begin
            nc = DIM_ONE;
        end else if ({1'b0, r_cols} > MAXC) begin
            nc = MAXC;
        end else begin
            nc = {1'b0, r_cols};
        end
        nr_t  = TOT_W'(nr);
        nc_t  = TOT_W'(nc);
        total = nr_t * nc_t;
    end

    // map the current row-major position to its place on the snake path
    always_comb begin
        if (!r_mode) begin
            snake_k = TOT_W'(r_r) * nc_t
                    + (r_r[0] ? (nc_t - TOT_W'(1) - TOT_W'(r_c)) : TOT_W'(r_c));
        end else begin
            snake_k = TOT_W'(r_c) * nr_t
                    + (r_c[0] ? (nr_t - TOT_W'(1) - TOT_W'(r_r)) : TOT_W'(r_r));
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_i         = r_i;
        n_j         = r_j;
        n_r         = r_r;
        n_c         = r_c;
        n_val       = r_val;
        n_out_value = r_out_value;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_last  = r_out_last;
        st_we       = 1'b0;
        st_wa       = AW'(r_count);
        st_ra       = AW'(r_i);
        so_we       = 1'b0;
        so_wa       = AW'(r_j);
        so_wd       = r_val;
        so_ra       = AW'(r_j - TOT_W'(1));
        ins_done    = 1'b0;
        cnt_inc     = (r_count == soms_pkg::CNT_MAX) ? r_count
                                                     : r_count + soms_pkg::CNT_W'(1);
        i_inc       = r_i + TOT_W'(1);
        o_s_tready  = (r_state == soms_pkg::ST_LOAD);
        o_m_tvalid  = (r_state == soms_pkg::ST_EMIT_WAIT);

        unique case (r_state)
            soms_pkg::ST_LOAD: begin
                if (i_s_tvalid) begin
                    st_we   = (int'(r_count) < CAPACITY);
                    n_count = cnt_inc;
                    if (int'(cnt_inc) >= int'(total)) begin
                        n_count = '0;
                        n_i     = '0;
                        n_state = soms_pkg::ST_SORT_RD;
                    end
                end
            end
            soms_pkg::ST_SORT_RD: begin
                n_state = soms_pkg::ST_SORT_LD;
            end
            soms_pkg::ST_SORT_LD: begin
                n_val = r_st_rdata;
                n_j   = r_i;
                if (r_i == '0) begin
                    so_we    = 1'b1;
                    so_wa    = '0;
                    so_wd    = r_st_rdata;
                    ins_done = 1'b1;
                end else begin
                    so_ra   = AW'(r_i - TOT_W'(1));
                    n_state = soms_pkg::ST_SORT_CMP;
                end
            end
            soms_pkg::ST_SORT_CMP: begin
                so_we = 1'b1;
                so_wa = AW'(r_j);
                if (r_so_rdata > r_val) begin
                    so_wd = r_so_rdata;
                    n_j   = r_j - TOT_W'(1);
                    if (r_j == TOT_W'(1)) begin
                        n_state = soms_pkg::ST_SORT_INS;
                    end else begin
                        so_ra = AW'(r_j - TOT_W'(2));
                    end
                end else begin
                    so_wd    = r_val;
                    ins_done = 1'b1;
                end
            end
            soms_pkg::ST_SORT_INS: begin
                so_we    = 1'b1;
                so_wa    = AW'(r_j);
                so_wd    = r_val;
                ins_done = 1'b1;
            end
            soms_pkg::ST_EMIT_RD: begin
                so_ra   = AW'(snake_k);
                n_state = soms_pkg::ST_EMIT_LD;
            end
            soms_pkg::ST_EMIT_LD: begin
                n_out_value = r_so_rdata;
                n_out_row   = soms_pkg::IDX_W'(r_r);
                n_out_col   = soms_pkg::IDX_W'(r_c);
                n_out_last  = (TOT_W'(r_r) == nr_t - TOT_W'(1))
                           && (TOT_W'(r_c) == nc_t - TOT_W'(1));
                n_state     = soms_pkg::ST_EMIT_WAIT;
            end
            soms_pkg::ST_EMIT_WAIT: begin
                if (i_m_tready) begin
                    if (r_out_last) begin
                        n_state = soms_pkg::ST_LOAD;
                    end else begin
                        if (TOT_W'(r_c) == nc_t - TOT_W'(1)) begin
                            n_c = '0;
                            n_r = r_r + RW'(1);
                        end else begin
                            n_c = r_c + CW'(1);
                        end
                        n_state = soms_pkg::ST_EMIT_RD;
                    end
                end
            end
        endcase

        // advance to the next element, or start emission
        if (ins_done) begin
            n_i = i_inc;
            if (i_inc == total) begin
                n_r     = '0;
                n_c     = '0;
                n_state = soms_pkg::ST_EMIT_RD;
            end else begin
                n_state = soms_pkg::ST_SORT_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= soms_pkg::ST_LOAD;
            r_count <= '0;
            r_rows  <= soms_pkg::DIM_W'(1);
            r_cols  <= soms_pkg::DIM_W'(1);
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    soms_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                    soms_pkg::CFG_COLS: r_cols <= i_cfg_data;
                    soms_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i         <= n_i;
        r_j         <= n_j;
        r_r         <= n_r;
        r_c         <= n_c;
        r_val       <= n_val;
        r_out_value <= n_out_value;
        r_out_row   <= n_out_row;
        r_out_col   <= n_out_col;
        r_out_last  <= n_out_last;
    end

    // arrival store
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= i_s_tdata;
        end
        r_st_rdata <= r_store[st_ra];
    end

    // sorted store
    always_ff @(posedge i_clk) begin
        if (so_we) begin
            r_sorted[so_wa] <= so_wd;
        end
        r_so_rdata <= r_sorted[so_ra];
    end

    assign o_m_tdata = {2'b00, r_out_col, r_out_row, r_out_value};
    assign o_m_tlast = r_out_last;

endmodule
`default_nettype wire

// ===== rtl/soms_checker.sv =====
// Port-level checks of the snake-order matrix sort, bound to its top level
`default_nettype none
`include "snake_order_matrix_sort_top_macros.svh"
module soms_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_s_tready,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [soms_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic                           o_m_tlast
);

    `SOMS_ASSERT(a_no_load_while_emit, i_clk, i_rst_n, !(o_s_tready && o_m_tvalid))
    `SOMS_ASSERT(a_hold_stalled_word, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    `SOMS_ASSERT(a_last_ends_frame, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tlast |=> !o_m_tvalid && o_s_tready)
    `SOMS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_m_tvalid && o_s_tready)

endmodule

bind snake_order_matrix_sort_top soms_checker u_soms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

// ===== bench/snake_order_matrix_sort_top_test.sv =====
// Self-checking bench for the snake-order matrix sort with random stalls on both stream sides
`default_nettype none
module snake_order_matrix_sort_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [soms_pkg::VALUE_W-1:0] value;
        logic [soms_pkg::IDX_W-1:0]          row;
        logic [soms_pkg::IDX_W-1:0]          col;
        logic                                last;
    } t_snake_word;

    localparam int IDLE_LIMIT   = 20000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 150;
    localparam int STORE_DEPTH  = soms_pkg::MAX_ROWS_DEF * soms_pkg::MAX_COLS_DEF;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [soms_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [soms_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_s_tvalid = 1'b0;
    logic [soms_pkg::S_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                            i_m_tready = 1'b0;
    wire                             o_s_tready;
    wire                             o_m_tvalid;
    wire [soms_pkg::M_TDATA_W-1:0]   o_m_tdata;
    wire                             o_m_tlast;

    snake_order_matrix_sort_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the block's registers and frame being loaded
    logic [soms_pkg::DIM_W-1:0]          cfg_rows = 4'd1;
    logic [soms_pkg::DIM_W-1:0]          cfg_cols = 4'd1;
    logic                                cfg_mode = 1'b0;
    logic signed [soms_pkg::VALUE_W-1:0] frame_loaded[$];
    t_snake_word                         words_due[$];
    logic [soms_pkg::S_TDATA_W-1:0]      values_to_send[$];

    int  fail_count    = 0;
    int  frames_sorted = 0;
    int  words_checked = 0;
    int  shapes_run    = 0;
    int  largest_frame = 0;
    int  random_sent   = 0;
    int  idle_cycles   = 0;
    int  send_gap      = 0;
    int  sink_stall    = 0;
    int  hold_left     = 0;
    int  holds_asked   = 0;
    int  holds_seen    = 0;
    bit  steady        = 1'b0;
    bit  s_fire        = 1'b0;

    function automatic int dim_in_use(logic [soms_pkg::DIM_W-1:0] raw, int limit);
        if (raw == 0) return 1;
        if (raw > limit) return limit;
        return int'(raw);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [soms_pkg::S_TDATA_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return $urandom_range(0, 7) - 4;
            default: return $urandom;
        endcase
    endfunction

    // stable sort of the finished frame, snake placement, row-major expectations
    function automatic void sort_and_place();
        int                                  nr, nc, total, j, r, c, p;
        logic signed [soms_pkg::VALUE_W-1:0] sorted[STORE_DEPTH];
        logic signed [soms_pkg::VALUE_W-1:0] grid[STORE_DEPTH];
        logic signed [soms_pkg::VALUE_W-1:0] v;
        t_snake_word                         w;
        nr = dim_in_use(cfg_rows, soms_pkg::MAX_ROWS_DEF);
        nc = dim_in_use(cfg_cols, soms_pkg::MAX_COLS_DEF);
        total = nr * nc;
        for (int i = 0; i < total; i++) begin
            v = frame_loaded[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        for (int k = 0; k < total; k++) begin
            if (cfg_mode == 1'b0) begin
                p = k % nc;
                r = k / nc;
                c = (r % 2 == 1) ? nc - 1 - p : p;
            end else begin
                p = k % nr;
                c = k / nr;
                r = (c % 2 == 1) ? nr - 1 - p : p;
            end
            grid[r*nc + c] = sorted[k];
        end
        for (int k = 0; k < total; k++) begin
            w.value = grid[k];
            w.row   = soms_pkg::IDX_W'(k / nc);
            w.col   = soms_pkg::IDX_W'(k % nc);
            w.last  = (k == total - 1);
            words_due.push_back(w);
        end
        frames_sorted++;
        if (total > largest_frame) largest_frame = total;
    endfunction

    function automatic void take_value(logic [soms_pkg::S_TDATA_W-1:0] v);
        frame_loaded.push_back(v);
        if (frame_loaded.size() >= dim_in_use(cfg_rows, soms_pkg::MAX_ROWS_DEF) *
                                   dim_in_use(cfg_cols, soms_pkg::MAX_COLS_DEF)) begin
            sort_and_place();
            frame_loaded.delete();
        end
    endfunction

    function automatic void check_word();
        t_snake_word w;
        if (words_due.size() == 0) begin
            $display("%0t: unexpected word %h last %b", $time, o_m_tdata, o_m_tlast);
            fail_count++;
            return;
        end
        w = words_due.pop_front();
        words_checked++;
        if (o_m_tdata[31:0] !== w.value) begin
            $display("%0t: out_value expected %h got %h", $time, w.value, o_m_tdata[31:0]);
            fail_count++;
        end
        if (o_m_tdata[34:32] !== w.row) begin
            $display("%0t: out_row expected %0d got %0d", $time, w.row, o_m_tdata[34:32]);
            fail_count++;
        end
        if (o_m_tdata[37:35] !== w.col) begin
            $display("%0t: out_col expected %0d got %0d", $time, w.col, o_m_tdata[37:35]);
            fail_count++;
        end
        if (o_m_tlast !== w.last) begin
            $display("%0t: last_out expected %b got %b", $time, w.last, o_m_tlast);
            fail_count++;
        end
    endfunction

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) take_value(i_s_tdata);
            if (o_m_tvalid && i_m_tready) check_word();
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
                $display("snake_order_matrix_sort_top_test failed");
                $finish;
            end
        end
    end

    // driver: advance to the next word once the current one is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                i_s_tvalid <= 1'b0;
            end else if (values_to_send.size() > 0) begin
                i_s_tdata  <= values_to_send.pop_front();
                i_s_tvalid <= 1'b1;
                send_gap = steady ? 0 : pick_gap();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (holds_asked != holds_seen) begin
            holds_seen = holds_asked;
            hold_left  = HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            sink_stall = steady ? 0 : pick_gap();
        end
    end

    task automatic write_reg(logic [soms_pkg::CFG_IDX_W-1:0] idx,
                             logic [soms_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic set_shape(logic [soms_pkg::DIM_W-1:0] rows,
                             logic [soms_pkg::DIM_W-1:0] cols, logic mode);
        write_reg(soms_pkg::CFG_ROWS, rows);
        write_reg(soms_pkg::CFG_COLS, cols);
        write_reg(soms_pkg::CFG_MODE, soms_pkg::CFG_DATA_W'(mode));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_rows = rows;
        cfg_cols = cols;
        cfg_mode = mode;
        shapes_run++;
        @(posedge i_clk);
    endtask

    task automatic queue_frames(int count);
        int total;
        total = dim_in_use(cfg_rows, soms_pkg::MAX_ROWS_DEF) *
                dim_in_use(cfg_cols, soms_pkg::MAX_COLS_DEF);
        for (int i = 0; i < count * total; i++) values_to_send.push_back(draw_value());
    endtask

    // wait for every word to drain, then let the block return to loading
    task automatic settle();
        do @(negedge i_clk);
        while (values_to_send.size() > 0 || i_s_tvalid || words_due.size() > 0 ||
               frame_loaded.size() > 0);
        repeat (8) @(negedge i_clk);
    endtask

    initial begin
        int nf, total;
        logic [soms_pkg::DIM_W-1:0] r, c;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset shape is 1x1: each word is its own frame
        values_to_send.push_back(32'h8000_0000);
        values_to_send.push_back(32'h7fff_ffff);
        settle();

        set_shape(4'd2, 4'd3, 1'b0);
        values_to_send.push_back(32'h7fff_ffff);
        values_to_send.push_back(32'h8000_0000);
        values_to_send.push_back(32'h0000_0000);
        values_to_send.push_back(32'hffff_ffff);
        values_to_send.push_back(32'h0000_0005);
        values_to_send.push_back(32'h0000_0005);
        settle();

        set_shape(4'd3, 4'd2, 1'b1);
        values_to_send.push_back(32'h0000_0001);
        values_to_send.push_back(32'hffff_fffe);
        values_to_send.push_back(32'h7fff_ffff);
        values_to_send.push_back(32'h8000_0000);
        values_to_send.push_back(32'h0000_0001);
        values_to_send.push_back(32'h5555_aaaa);
        settle();

        // zero rows and oversize cols clamp to 1x8
        set_shape(4'd0, 4'd15, 1'b0);
        queue_frames(1);
        settle();

        // hold the output while the sender keeps pushing
        set_shape(4'd3, 4'd3, 1'b1);
        steady = 1'b1;
        holds_asked++;
        queue_frames(3);
        settle();

        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) begin
                r  = $urandom_range(0, 1) ? 4'd8 : 4'd15;
                c  = $urandom_range(0, 1) ? 4'd8 : 4'd15;
                nf = 1;
            end else begin
                r  = soms_pkg::DIM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 15)
                                                                 : $urandom_range(0, 4));
                c  = soms_pkg::DIM_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 15)
                                                                 : $urandom_range(0, 4));
                nf = $urandom_range(1, 3);
            end
            steady = ($urandom_range(0, 3) == 0);
            set_shape(r, c, ($urandom_range(0, 1) == 1));
            total = dim_in_use(r, soms_pkg::MAX_ROWS_DEF) * dim_in_use(c, soms_pkg::MAX_COLS_DEF);
            queue_frames(nf);
            random_sent += nf * total;
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (words_due.size() > 0) begin
            $display("%0t: %0d words never arrived", $time, words_due.size());
            fail_count++;
        end
        $display("sorted %0d matrices over %0d shapes, both snake directions, largest %0d",
                 frames_sorted, shapes_run, largest_frame);
        $display("checked %0d result words, %0d mismatches", words_checked, fail_count);
        if (fail_count == 0) begin
            $display("snake_order_matrix_sort_top_test passed");
        end else begin
            $display("snake_order_matrix_sort_top_test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/soms_pkg.sv
rtl/snake_order_matrix_sort_top.sv
rtl/soms_checker.sv
bench/snake_order_matrix_sort_top_test.sv
